FILE: src/xbtu_pkg.sv
// Shared types and constants for the x86 branch target unfilter.
// No dependencies; every module of the block imports this package.
package xbtu_pkg;

  localparam int unsigned PosBits    = 32;
  localparam int unsigned WordBits   = 32;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrBits   = $clog2(QueueDepth);
  localparam int unsigned QCntBits   = $clog2(QueueDepth + 1);

  localparam logic [7:0] OpcCall = 8'hE8;
  localparam logic [7:0] OpcJmp  = 8'hE9;

  // Byte counts of a queued request, stored minus one.
  localparam logic [1:0] CntOne  = 2'd0;
  localparam logic [1:0] CntFour = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_t;

  // One queued request: up to four bytes, little-endian, emitted low byte first.
  typedef struct packed {
    logic [WordBits-1:0] word;
    logic [1:0]          cnt_m1;
    logic                last;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_push_t;

  typedef struct packed {
    logic collecting;
    logic pos_zero;
  } front_stat_t;

endpackage

FILE: src/xbtu_front.sv
// Front end: accepts stream bytes, tracks position and operand collection,
// and turns each byte into a queued request. Depends on xbtu_pkg.
module xbtu_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  xbtu_pkg::in_t        in_i,
  input  logic                 q_full_i,
  output xbtu_pkg::cmd_push_t  push_o,
  output xbtu_pkg::front_stat_t stat_o
);
  import xbtu_pkg::*;

  logic [PosBits-1:0] pos_q, pos_d;
  logic [PosBits-1:0] base_q, base_d;
  logic [1:0]         cnt_q, cnt_d;
  logic               coll_q, coll_d;
  logic [7:0]         ob_q [3];
  logic               accept;
  logic [7:0]         b;
  logic               eos;
  logic [WordBits-1:0] raw_word;

  assign accept = in_valid_i & ~q_full_i;
  assign b      = in_i.data_byte;
  assign eos    = in_i.end_of_stream;
  assign raw_word = {ob_q[0], ob_q[1], ob_q[2], b};

  always_comb begin
    pos_d  = pos_q + PosBits'(1);
    base_d = base_q;
    cnt_d  = cnt_q;
    coll_d = coll_q;
    push_o = '0;
    if (coll_q) begin
      if (cnt_q == CntFour) begin
        push_o.valid      = 1'b1;
        push_o.cmd.word   = raw_word - WordBits'(base_q);
        push_o.cmd.cnt_m1 = CntFour;
        push_o.cmd.last   = eos;
        coll_d = 1'b0;
        cnt_d  = '0;
      end else if (eos) begin
        // short tail: flush collected bytes raw
        push_o.valid      = 1'b1;
        push_o.cmd.cnt_m1 = cnt_q;
        push_o.cmd.last   = 1'b1;
        case (cnt_q)
          2'd0:    push_o.cmd.word = {24'h0, b};
          2'd1:    push_o.cmd.word = {16'h0, b, ob_q[0]};
          default: push_o.cmd.word = {8'h0, b, ob_q[1], ob_q[0]};
        endcase
        coll_d = 1'b0;
        cnt_d  = '0;
      end else begin
        cnt_d = cnt_q + 2'd1;
      end
    end else begin
      push_o.valid      = 1'b1;
      push_o.cmd.word   = {24'h0, b};
      push_o.cmd.cnt_m1 = CntOne;
      push_o.cmd.last   = eos;
      if ((b == OpcCall || b == OpcJmp) && !eos) begin
        coll_d = 1'b1;
        cnt_d  = '0;
        base_d = pos_q + PosBits'(1);
      end
    end
    if (eos) begin
      pos_d  = '0;
      cnt_d  = '0;
      coll_d = 1'b0;
      base_d = '0;
    end
    push_o.valid = push_o.valid & accept;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      base_q <= '0;
      cnt_q  <= '0;
      coll_q <= 1'b0;
    end else if (accept) begin
      pos_q  <= pos_d;
      base_q <= base_d;
      cnt_q  <= cnt_d;
      coll_q <= coll_d;
    end
  end

  // hold operand bytes; only entries written in this collection are read
  always_ff @(posedge clk_i) begin
    if (accept && coll_q && !eos) begin
      case (cnt_q)
        2'd0:    ob_q[0] <= b;
        2'd1:    ob_q[1] <= b;
        2'd2:    ob_q[2] <= b;
        default: ;
      endcase
    end
  end

  assign stat_o.collecting = coll_q;
  assign stat_o.pos_zero   = (pos_q == '0);

endmodule

FILE: src/xbtu_queue.sv
// Short request queue between front end and back end.
// Depends on xbtu_pkg for the request type and depth.
module xbtu_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  xbtu_pkg::cmd_push_t push_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                valid_o,
  output xbtu_pkg::cmd_t      head_o
);
  import xbtu_pkg::*;

  cmd_t                mem_q [QueueDepth];
  logic [QPtrBits-1:0] wr_q, rd_q;
  logic [QCntBits-1:0] cnt_q;
  logic                do_pop;

  assign full_o  = (cnt_q == QCntBits'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i.valid) wr_q <= wr_q + QPtrBits'(1);
      if (do_pop)       rd_q <= rd_q + QPtrBits'(1);
      case ({push_i.valid, do_pop})
        2'b10:   cnt_q <= cnt_q + QCntBits'(1);
        2'b01:   cnt_q <= cnt_q - QCntBits'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) mem_q[wr_q] <= push_i.cmd;
  end

endmodule

FILE: src/xbtu_back.sv
// Back end: holds one request and emits its bytes one per cycle unless stalled.
// Depends on xbtu_pkg.
module xbtu_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  xbtu_pkg::cmd_t  q_head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output xbtu_pkg::out_t  out_o
);
  import xbtu_pkg::*;

  cmd_t       cur_q;
  logic       cur_valid_q;
  logic [1:0] idx_q;
  logic       out_acc;
  logic       final_byte;

  assign out_acc    = cur_valid_q & ~out_stall_i;
  assign final_byte = (idx_q == cur_q.cnt_m1);
  // refill when empty or when the final byte leaves this cycle
  assign pop_o      = q_valid_i & (~cur_valid_q | (out_acc & final_byte));

  assign out_valid_o    = cur_valid_q;
  assign out_o.out_byte = cur_q.word[{idx_q, 3'b000} +: 8];
  assign out_o.out_last = cur_q.last & final_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (pop_o) begin
      cur_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (out_acc) begin
      if (final_byte) begin
        cur_valid_q <= 1'b0;
        idx_q       <= '0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= q_head_i;
  end

endmodule

FILE: src/x86_branch_target_unfilter_core.sv
// Top level of the x86 branch target unfilter (E8/E9 call/jump decode).
// Instantiates xbtu_front, xbtu_queue and xbtu_back; depends on xbtu_pkg.
//
// The core restores a byte stream that went through an x86 call/jump filter.
// Plain bytes pass straight through; after an 0xE8 or 0xE9 opcode the next
// four bytes are taken as a big-endian word, the stream position of the first
// of them is subtracted modulo 2^32, and the result leaves as four
// little-endian bytes. A buffer that ends inside an operand flushes the
// collected bytes raw, and the position restarts at zero after every byte
// flagged end_of_stream. Input takes one byte per cycle while the queue has
// room; the front end turns each accepted byte into a request in the same
// cycle (operand bytes wait until the fourth completes the word) and
// writes it into a four-entry request queue, and the back end emits one byte
// per cycle while the output is not stalled, so sustained throughput is one
// byte per clock in each direction. With no stall, a request passes through
// the queue and the back end's request register before its first byte leaves.
// The front end stalls only when the request queue is full; the output side
// may stall at any time without blocking input until the queue fills.
module x86_branch_target_unfilter_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  xbtu_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output xbtu_pkg::out_t out_o
);
  import xbtu_pkg::*;

  cmd_push_t   push;
  front_stat_t front_stat;
  cmd_t        q_head;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;

  // stall input while the request queue has no room
  assign in_stall_o = q_full;

  xbtu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .stat_o     (front_stat)
  );

  xbtu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  xbtu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  // never push into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push.valid && q_full))
    else $error("request pushed into full queue");

  // back end pops only what the queue holds
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("request popped from empty queue");

  // end of buffer returns the front end to position zero, not collecting
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_i.end_of_stream)
      |=> (front_stat.pos_zero && !front_stat.collecting))
    else $error("front end not cleared after end of stream");

  // an accepted opcode outside collection starts operand collection
  a_opcode_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !front_stat.collecting && !in_i.end_of_stream
      && (in_i.data_byte == OpcCall || in_i.data_byte == OpcJmp))
      |=> front_stat.collecting)
    else $error("opcode did not start operand collection");

endmodule

FILE: verif/x86_branch_target_unfilter_core_test.sv
// Self-checking testbench for x86_branch_target_unfilter_core.
// Predicts the restored byte stream per accepted request; depends on xbtu_pkg.
`timescale 1ns / 1ps

module x86_branch_target_unfilter_core_test;
  import xbtu_pkg::*;

  localparam int unsigned MaxIdle    = 4;
  localparam int unsigned RandItems  = 72;
  localparam int unsigned DrainTicks = 20;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_stall_i = 1'b0;
  in_t  in_i        = '0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_o;

  // Requests still to be presented, and restored bytes still to come out.
  in_t  pending_q[$];
  out_t restored_q[$];

  // Shadow of the unfilter state.
  logic [PosBits-1:0]  pos_r;
  logic [7:0]          opnd_r [3];
  logic [1:0]          opnd_cnt_r;
  logic                collecting_r;
  logic [WordBits-1:0] base_r;

  // Handshake bookkeeping shared between the posedge monitor and the
  // negedge drivers; the taken flags are set on the posedge and cleared on the negedge.
  bit   in_taken       = 1'b0;
  bit   in_busy        = 1'b0;
  bit   in_calm        = 1'b0;
  int   in_gap         = 0;
  in_t  in_req         = '0;
  bit   out_taken      = 1'b0;
  bit   out_calm       = 1'b0;
  int   out_stall_left = 0;
  int   fail_cnt       = 0;

  x86_branch_target_unfilter_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic push_restored(input logic [7:0] value, input logic last);
    out_t res;
    res.out_byte = value;
    res.out_last = last;
    restored_q.push_back(res);
  endtask

  // Work out the restored bytes that one accepted request releases.
  task automatic predict_restored(input in_t req);
    logic [PosBits-1:0]  here;
    logic [WordBits-1:0] word;
    logic [7:0]          b;
    logic                eos;
    b    = req.data_byte;
    eos  = req.end_of_stream;
    here = pos_r;
    pos_r = here + PosBits'(1);
    if (collecting_r) begin
      if (opnd_cnt_r == CntFour) begin
        // Fourth operand byte: big-endian word minus its base, sent little-endian.
        word = {opnd_r[0], opnd_r[1], opnd_r[2], b} - base_r;
        for (int i = 0; i < 4; i++) push_restored(word[8*i +: 8], eos && (i == 3));
        collecting_r = 1'b0;
        opnd_cnt_r   = '0;
      end else if (eos) begin
        // Short tail: flush what was collected, raw, then the arriving byte.
        for (int i = 0; i < 3; i++) begin
          if (i < int'(opnd_cnt_r)) push_restored(opnd_r[i], 1'b0);
        end
        push_restored(b, 1'b1);
        collecting_r = 1'b0;
        opnd_cnt_r   = '0;
      end else begin
        opnd_r[opnd_cnt_r] = b;
        opnd_cnt_r = opnd_cnt_r + 2'd1;
      end
    end else begin
      push_restored(b, eos);
      // An opcode on the final byte starts no collection.
      if ((b == OpcCall || b == OpcJmp) && !eos) begin
        collecting_r = 1'b1;
        opnd_cnt_r   = '0;
        base_r       = WordBits'(here + PosBits'(1));
      end
    end
    if (eos) begin
      pos_r        = '0;
      opnd_cnt_r   = '0;
      collecting_r = 1'b0;
      base_r       = '0;
    end
  endtask

  task automatic queue_byte(input logic [7:0] value, input logic eos);
    in_t req;
    req.data_byte     = value;
    req.end_of_stream = eos;
    pending_q.push_back(req);
  endtask

  // Random buffer, biased toward opcodes so operand collection and short
  // tails come up often; the final byte always closes the buffer.
  task automatic queue_random_buffer(input int len);
    int          pick;
    logic [7:0]  value;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       value = OpcCall;
        1:       value = OpcJmp;
        2:       value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: value = 8'($urandom_range(0, 255));
      endcase
      queue_byte(value, i == len - 1);
    end
  endtask

  // Accept requests into the predictor, then check restored bytes. Predict
  // first so an expectation made at this edge is already in place.
  always @(posedge clk_i) begin : monitor
    out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_restored(in_i);
        in_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        out_taken = 1'b1;
        if (restored_q.size() == 0) begin
          $error("out_byte: expected none, actual %h", out_o.out_byte);
          fail_cnt++;
        end else begin
          want = restored_q.pop_front();
          if (out_o.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, actual %h", want.out_byte, out_o.out_byte);
            fail_cnt++;
          end
          if (out_o.out_last !== want.out_last) begin
            $error("out_last: expected %b, actual %b", want.out_last, out_o.out_last);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Request driver: drop an accepted request, wait out its gap, then present
  // the next one. Valid is assigned once per edge so back-to-back requests
  // keep it high.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        in_taken = 1'b0;
        in_busy  = 1'b0;
      end
      if (!in_busy) begin
        if (in_gap != 0) begin
          in_gap--;
        end else if (pending_q.size() != 0) begin
          in_req  = pending_q.pop_front();
          in_busy = 1'b1;
          // Switch now and then between idling and full-rate stretches.
          if ($urandom_range(0, 11) == 0) in_calm = !in_calm;
          in_gap = in_calm ? 0 : $urandom_range(0, MaxIdle);
        end
      end
      in_valid_i <= in_busy;
      in_i       <= in_req;
    end
  end

  // Output stall: after each restored byte, hold the output off for a
  // random number of cycles.
  always @(negedge clk_i) begin
    if (out_taken) begin
      out_taken = 1'b0;
      if ($urandom_range(0, 11) == 0) out_calm = !out_calm;
      out_stall_left = out_calm ? 0 : $urandom_range(0, MaxIdle);
    end
    if (out_stall_left != 0) begin
      out_stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin : stimulus
    int rand_cnt;
    int len;
    pos_r        = '0;
    opnd_r       = '{default: '0};
    opnd_cnt_r   = '0;
    collecting_r = 1'b0;
    base_r       = '0;

    // Call with full operand, plain bytes at both extremes, then a jump whose
    // operand holds an opcode that must not be rescanned.
    queue_byte(OpcCall, 1'b0);
    queue_byte(8'h12, 1'b0);
    queue_byte(8'h34, 1'b0);
    queue_byte(8'h56, 1'b0);
    queue_byte(8'h78, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(OpcJmp, 1'b0);
    queue_byte(OpcCall, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h02, 1'b0);
    queue_byte(8'h03, 1'b0);
    queue_byte(8'hFF, 1'b1);
    // Zero operand at the buffer end: the subtraction underflows.
    queue_byte(OpcJmp, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);
    // Opcode as the final byte of a buffer.
    queue_byte(OpcCall, 1'b1);
    // Short tails with none, one and two operand bytes collected.
    queue_byte(OpcJmp, 1'b0);
    queue_byte(8'hAA, 1'b1);
    queue_byte(OpcCall, 1'b0);
    queue_byte(OpcCall, 1'b0);
    queue_byte(OpcJmp, 1'b1);
    queue_byte(OpcCall, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);

    rand_cnt = 0;
    while (rand_cnt < RandItems) begin
      len = $urandom_range(1, 12);
      queue_random_buffer(len);
      rand_cnt += len;
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every request presented and accepted, every restored byte seen.
    while (pending_q.size() != 0 || in_busy) @(negedge clk_i);
    while (restored_q.size() != 0) @(negedge clk_i);
    repeat (DrainTicks) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: sim.f
src/xbtu_pkg.sv
src/xbtu_front.sv
src/xbtu_queue.sv
src/xbtu_back.sv
src/x86_branch_target_unfilter_core.sv
verif/x86_branch_target_unfilter_core_test.sv
